// File: hdl/prime_count_odd_sieve_core_assert.svh
// assertion macros for the odd sieve prime counter
`ifndef PRIME_COUNT_ODD_SIEVE_CORE_ASSERT_SVH
`define PRIME_COUNT_ODD_SIEVE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PCOS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PCOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pcos_pkg.sv
// shared constants for the odd sieve prime counter
package pcos_pkg;

  // limit word width and result width
  localparam int unsigned NW = 17;
  localparam int unsigned CW = 13;
  // walk value width: multiples and squares run slightly past the limit
  localparam int unsigned JW = 18;
  // odd candidate width: candidates stay below the square root of the limit
  localparam int unsigned IW = 10;
  // default upper bound on the limit
  localparam int unsigned MaxNDefault = 65536;

endpackage

// File: hdl/pcos_ram.sv
// generic single-write, single-read ram with registered read data
module pcos_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/prime_count_odd_sieve_core.sv
// Prime counter: sieve of Eratosthenes over odd numbers, bitmap kept in one ram.
//
// Usage: drive n_limit_i and pulse start_i while busy_o is low; the word is
// taken at that clock edge. busy_o rises on the next cycle and stays high
// until the result is shown. prime_count_o carries the number of primes
// below n_limit_i (limit saturated to MAX_N) and is valid for exactly one
// cycle, marked by done_o; the receiver has no way to stall it.
// For a limit n the block first sets the odd bitmap back to "maybe prime"
// (one ram write a cycle), then looks up each odd candidate below sqrt(n)
// and walks the odd multiples of every candidate still marked, from its
// square. The marking loop reads one multiple each cycle and writes back the
// previous one, if it read as set, through the single ram. Limits of 2 or
// less go straight to the result. One request is worked at a time.
// Reset returns the controller to idle; the bitmap needs no clearing pass at
// reset since each request refills the part it touches.
module prime_count_odd_sieve_core #(
  parameter int unsigned MAX_N = pcos_pkg::MaxNDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [pcos_pkg::NW-1:0] n_limit_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [pcos_pkg::CW-1:0] prime_count_o
);

  // limits never exceed the input word range, so the bitmap stops there
  localparam int unsigned NCap     = (MAX_N < (2 ** pcos_pkg::NW)) ? MAX_N
                                                                   : (2 ** pcos_pkg::NW);
  localparam int unsigned MapDepth = NCap / 2 + 1;
  localparam int unsigned KW       = $clog2(MapDepth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StLook = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StMark = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [pcos_pkg::NW-1:0] n_q, n_d;
  logic [pcos_pkg::NW-1:0] count_q, count_d;
  logic [KW-1:0]           idx_q, idx_d;
  logic [pcos_pkg::IW-1:0] i_q, i_d;
  logic [pcos_pkg::JW-1:0] sq_q, sq_d;
  logic [pcos_pkg::JW-1:0] j_q, j_d;
  logic                    pend_q, pend_d;
  logic [KW-1:0]           pend_k_q, pend_k_d;
  logic                    done_q, done_d;
  logic [pcos_pkg::CW-1:0] res_q, res_d;

  logic                    start_ok;
  logic [pcos_pkg::NW-1:0] n_sat;
  logic [KW-1:0]           last_k;
  logic [pcos_pkg::JW-1:0] n_ext;
  logic                    ram_we, ram_wdata, ram_re, ram_rdata;
  logic [KW-1:0]           ram_waddr, ram_raddr;

  assign start_ok = start_i && (state_q == StIdle);
  assign n_sat    = ({15'd0, n_limit_i} > 32'(MAX_N)) ? pcos_pkg::NW'(MAX_N) : n_limit_i;
  assign last_k   = KW'((n_q - pcos_pkg::NW'(1)) >> 1);
  assign n_ext    = pcos_pkg::JW'(n_q);

  // bitmap: one bit per odd number, bit k for 2k+1
  pcos_ram #(
    .Width (1),
    .Depth (MapDepth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequencer: refill, candidate lookup, multiple marking
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    count_d   = count_q;
    idx_d     = idx_q;
    i_d       = i_q;
    sq_d      = sq_q;
    j_d       = j_q;
    pend_d    = 1'b0;
    pend_k_d  = pend_k_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = KW'(i_q >> 1);

    // write back a multiple read in the previous cycle if its bit was still set, and drop it from the count
    if (pend_q && ram_rdata) begin
      ram_we    = 1'b1;
      ram_waddr = pend_k_q;
      ram_wdata = 1'b0;
      count_d   = count_q - pcos_pkg::NW'(1);
    end

    case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = n_sat;
          count_d = n_sat >> 1;
          idx_d   = '0;
          i_d     = pcos_pkg::IW'(3);
          sq_d    = pcos_pkg::JW'(9);
          if (n_sat <= pcos_pkg::NW'(2)) begin
            count_d = '0;
            state_d = StDone;
          end else begin
            state_d = StInit;
          end
        end
      end
      StInit: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = 1'b1;
        idx_d     = idx_q + KW'(1);
        if (idx_q == last_k) begin
          state_d = StLook;
        end
      end
      StLook: begin
        if (sq_q >= n_ext) begin
          state_d = StDone;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = KW'(i_q >> 1);
          state_d   = StChk;
        end
      end
      StChk: begin
        if (ram_rdata) begin
          j_d     = sq_q;
          state_d = StMark;
        end else begin
          i_d     = i_q + pcos_pkg::IW'(2);
          sq_d    = sq_q + (pcos_pkg::JW'(i_q) << 2) + pcos_pkg::JW'(4);
          state_d = StLook;
        end
      end
      StMark: begin
        if (j_q < n_ext) begin
          ram_re    = 1'b1;
          ram_raddr = j_q[KW:1];
          pend_d    = 1'b1;
          pend_k_d  = j_q[KW:1];
          j_d       = j_q + (pcos_pkg::JW'(i_q) << 1);
        end else begin
          i_d     = i_q + pcos_pkg::IW'(2);
          sq_d    = sq_q + (pcos_pkg::JW'(i_q) << 2) + pcos_pkg::JW'(4);
          state_d = StLook;
        end
      end
      StDone: begin
        done_d  = 1'b1;
        res_d   = count_q[pcos_pkg::CW-1:0];
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    count_q  <= count_d;
    idx_q    <= idx_d;
    i_q      <= i_d;
    sq_q     <= sq_d;
    j_q      <= j_d;
    pend_k_q <= pend_k_d;
    res_q    <= res_d;
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign prime_count_o = res_q;

  `include "prime_count_odd_sieve_core_assert.svh"

  // write-back never lands on the entry being read
  `PCOS_ASSERT_NOW(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr,
    "bitmap read and write hit the same entry")
  // an accepted word makes the block busy
  `PCOS_ASSERT_NEXT(a_start_busy, start_ok, busy_o, "accepted word did not raise busy")
  // the result strobe is never raised back to back
  `PCOS_ASSERT_NEXT(a_done_pulse, done_o, !done_o,
    "result strobe longer than one cycle")
  // write-backs only follow a marking read
  `PCOS_ASSERT_NOW(a_pend_mark, pend_q, $past(state_q) == StMark,
    "write-back without a marking read")

endmodule

// File: verif/tb_prime_count_odd_sieve_core.sv
// self-checking testbench for the odd sieve prime counter
`timescale 1ns / 1ps

module tb_prime_count_odd_sieve_core;

  localparam int unsigned MaxN = pcos_pkg::MaxNDefault;
  localparam int unsigned MapDepth = MaxN / 2 + 1;
  localparam int unsigned DrainCycles = 50;

  // one pending request word with its pacing
  typedef struct {
    logic [pcos_pkg::NW-1:0] limit;
    int unsigned             idle_pct;
    bit                      wait_drain;
  } limit_req_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic [pcos_pkg::NW-1:0] n_limit_i = '0;
  logic                    busy_o;
  logic                    done_o;
  logic [pcos_pkg::CW-1:0] prime_count_o;

  limit_req_t              limit_queue[$];
  logic [pcos_pkg::CW-1:0] count_due[$];
  bit                      odd_map[MapDepth];
  int unsigned             errors = 0;
  int unsigned             words_sent = 0;
  int unsigned             results_seen = 0;
  int unsigned             saturated_seen = 0;
  int unsigned             largest_limit = 0;

  prime_count_odd_sieve_core #(
    .MAX_N(MaxN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .n_limit_i    (n_limit_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .prime_count_o(prime_count_o)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // odd-only sieve: count of primes below the limit (saturated to MaxN), wrapped to the result width
  function automatic logic [pcos_pkg::CW-1:0] count_primes_below(
    logic [pcos_pkg::NW-1:0] limit
  );
    longint unsigned n;
    longint unsigned total;
    longint unsigned i;
    longint unsigned j;
    n = 64'(limit);
    if (n > MaxN) n = MaxN;
    for (int k = 0; k < MapDepth; k++) odd_map[k] = 1'b1;
    if (n <= 2) return '0;
    total = n - 1;
    for (i = 3; i * i < n; i += 2) begin
      if (odd_map[i >> 1]) begin
        for (j = i * i; j < n; j += 2 * i) begin
          if (odd_map[j >> 1]) begin
            odd_map[j >> 1] = 1'b0;
            total--;
          end
        end
      end
    end
    total -= (n + 1) / 2 - 1;
    return total[pcos_pkg::CW-1:0];
  endfunction

  // driver: offer the next word at random pacing and hold it until the block is free
  always @(posedge clk_i) begin : drive_words
    bit         took;
    limit_req_t nxt;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      n_limit_i <= '0;
    end else begin
      took = start_i && !busy_o;
      if (took) begin
        count_due.push_back(count_primes_below(n_limit_i));
        words_sent++;
        if (n_limit_i > MaxN) saturated_seen++;
        if (n_limit_i > largest_limit) largest_limit = 32'(n_limit_i);
      end
      if (start_i && !took) begin
        // hold the word until the block takes it
      end else if (limit_queue.size() != 0 &&
                   !(limit_queue[0].wait_drain && count_due.size() != 0) &&
                   $urandom_range(99) >= limit_queue[0].idle_pct) begin
        nxt = limit_queue.pop_front();
        start_i   <= 1'b1;
        n_limit_i <= nxt.limit;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare each strobed count with the oldest prediction
  always @(posedge clk_i) begin : check_counts
    logic [pcos_pkg::CW-1:0] want;
    if (rst_ni && done_o) begin
      if (count_due.size() == 0) begin
        $display("%0t: result with none pending, expected none actual %0d",
                 $time, prime_count_o);
        errors++;
      end else begin
        want = count_due.pop_front();
        results_seen++;
        if (prime_count_o !== want) begin
          $display("%0t: prime_count mismatch, expected %0d actual %0d",
                   $time, want, prime_count_o);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : run_sequence
    limit_req_t req;
    int unsigned sel;
    int unsigned phase_pct[3];
    logic [pcos_pkg::NW-1:0] directed[$];
    phase_pct[0] = 38;
    phase_pct[1] = 80;
    phase_pct[2] = 0;
    // edges of the range, square boundaries and saturation above the bound
    directed = '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd8, 17'd9, 17'd10,
                 17'd24, 17'd25, 17'd26, 17'd49, 17'd100, 17'd121, 17'd122,
                 17'd1000, 17'd4096, 17'd65536, 17'd65537, 17'd131071};
    foreach (directed[d]) begin
      req.limit      = directed[d];
      req.idle_pct   = phase_pct[0];
      req.wait_drain = (d == 0);
      limit_queue.push_back(req);
    end
    // random part: mostly small limits, a few mid-size, rarely the full range
    for (int r = 0; r < 80; r++) begin
      sel = $urandom_range(99);
      if (sel < 1) req.limit = pcos_pkg::NW'($urandom_range(131071, 0));
      else if (sel < 7) req.limit = pcos_pkg::NW'($urandom_range(32767, 4096));
      else if (sel < 17) req.limit = pcos_pkg::NW'($urandom_range(15, 0));
      else req.limit = pcos_pkg::NW'($urandom_range(4095, 16));
      req.idle_pct   = phase_pct[r / 27];
      req.wait_drain = (r == 27) || (r == 54) || ($urandom_range(99) < 3);
      limit_queue.push_back(req);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for all words taken and all counts back, then watch for strays
    do @(posedge clk_i);
    while (limit_queue.size() != 0 || start_i || count_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (count_due.size() != 0) begin
      $display("%0t: %0d counts never arrived", $time, count_due.size());
      errors++;
    end

    $display("covered %0d limits (largest %0d, %0d above the bound), %0d counts checked",
             words_sent, largest_limit, saturated_seen, results_seen);
    $display("sender pacing: 38%% idle, 80%% idle, back-to-back; with drain pauses");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000_000;
    $display("%0t: timeout with %0d counts pending", $time, count_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pcos_pkg.sv
hdl/pcos_ram.sv
hdl/prime_count_odd_sieve_core.sv
verif/tb_prime_count_odd_sieve_core.sv
